[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/jse_pkg.sv]
// Shared types, constants and character helpers for the JSON string escaper.
package jse_pkg;

   localparam int LENGTH_BITS_DEFAULT   = 24;
   localparam int CAPACITY_BITS_DEFAULT = 16;
   localparam int CAPACITY_RESET        = 65535;

   // CSR port
   localparam int   CSR_ADDR_BITS    = 3;
   localparam int   CSR_DATA_BITS    = 32;
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   // Result slots of one request, in emission order
   localparam int NUM_SLOTS  = 9;
   localparam int SLOT_BITS  = 4;
   localparam int CHAR_SLOTS = 6;
   localparam logic [SLOT_BITS-1:0] SLOT_OPEN   = 4'd0;
   localparam logic [SLOT_BITS-1:0] SLOT_CHAR   = 4'd1;
   localparam logic [SLOT_BITS-1:0] SLOT_ESC    = 4'd2;
   localparam logic [SLOT_BITS-1:0] SLOT_PAD_HI = 4'd3;
   localparam logic [SLOT_BITS-1:0] SLOT_PAD_LO = 4'd4;
   localparam logic [SLOT_BITS-1:0] SLOT_HEX_HI = 4'd5;
   localparam logic [SLOT_BITS-1:0] SLOT_HEX_LO = 4'd6;
   localparam logic [SLOT_BITS-1:0] SLOT_CLOSE  = 4'd7;
   localparam logic [SLOT_BITS-1:0] SLOT_STATUS = 4'd8;

   // Characters
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_SHORT,
      KIND_UNICODE
   } kind_type;

   // Work left for one request: which slots still emit, plus the byte data
   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [7:0]           char_byte;
      kind_type             kind;
      logic                 overflow;
   } plan_type;

   // Letter of a two-byte escape, zero if the byte has none
   function automatic logic [7:0] short_escape(input logic [7:0] c);
      logic [7:0] e;
      case (c)
         8'h08:     e = 8'h62;  // b
         8'h09:     e = 8'h74;  // t
         8'h0A:     e = 8'h6E;  // n
         8'h0C:     e = 8'h66;  // f
         8'h0D:     e = 8'h72;  // r
         CH_QUOTE:  e = CH_QUOTE;
         CH_BSLASH: e = CH_BSLASH;
         default:   e = 8'h00;
      endcase
      return e;
   endfunction

   function automatic kind_type char_kind(input logic [7:0] c);
      kind_type k;
      if (short_escape(c) != 8'h00) begin
         k = KIND_SHORT;
      end else if (c >= CH_SPACE && c <= CH_TILDE) begin
         k = KIND_PLAIN;
      end else begin
         k = KIND_UNICODE;
      end
      return k;
   endfunction

   function automatic logic [2:0] kind_length(input kind_type k);
      logic [2:0] n;
      case (k)
         KIND_PLAIN:   n = 3'd1;
         KIND_SHORT:   n = 3'd2;
         KIND_UNICODE: n = 3'd6;
         default:      n = 3'd6;
      endcase
      return n;
   endfunction

   // Upper-case hex digit
   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] d;
      if (n < 4'd10) begin
         d = CH_ZERO + {4'h0, n};
      end else begin
         d = 8'h37 + {4'h0, n};
      end
      return d;
   endfunction

endpackage

[rtl/jse_budget.sv]
// Output budget tracking: position, length and overflow state, and the per-request plan.
module jse_budget
   import jse_pkg::*;
#(
   parameter int LENGTH_BITS   = LENGTH_BITS_DEFAULT,
   parameter int CAPACITY_BITS = CAPACITY_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               char_byte,
   input  logic                     has_char,
   input  logic                     first_of_string,
   input  logic                     end_of_string,
   input  logic [CAPACITY_BITS-1:0] capacity,
   output plan_type                 plan,
   output logic [LENGTH_BITS-1:0]   plan_length
);

   localparam int PW = CAPACITY_BITS + 1;

   logic [CAPACITY_BITS-1:0] wp_ff, wp_in;
   logic [LENGTH_BITS-1:0]   len_ff, len_in;
   logic                     ovf_ff, ovf_in;

   kind_type      kind;
   logic [2:0]    klen;
   logic [PW-1:0] capx, wp1, wpk, wp2, wp2_close;
   logic          ovf0, ovf1, fit_char, fit_close, open_emit;
   logic [2:0]    n_char;
   logic [3:0]    inc;
   logic [LENGTH_BITS-1:0] len_base;
   logic [LENGTH_BITS:0]   len_sum;

   always_comb begin
      kind = char_kind(char_byte);
      klen = kind_length(kind);
      capx = {1'b0, capacity};

      // Opening quote always takes position 0
      ovf0      = first_of_string ? 1'b0 : ovf_ff;
      wp1       = first_of_string ? PW'(1) : {1'b0, wp_ff};
      open_emit = first_of_string && (capx > PW'(1));

      // Character: whole escape must fit, last byte lost to the terminator slot
      wpk      = wp1 + PW'(klen);
      fit_char = has_char && !ovf0 && (wpk <= capx);
      if (!fit_char) begin
         n_char = 3'd0;
      end else if (wpk < capx) begin
         n_char = klen;
      end else begin
         n_char = klen - 3'd1;
      end
      wp2  = fit_char ? wpk : wp1;
      ovf1 = ovf0 | (has_char & !fit_char);

      // Closing quote needs room for the terminator too
      wp2_close = wp2 + PW'(2);
      fit_close = end_of_string && !ovf1 && (wp2_close <= capx);
      ovf_in    = ovf1 | (end_of_string & !fit_close);
      wp_in     = fit_close ? wp2[CAPACITY_BITS-1:0] + CAPACITY_BITS'(1)
                            : wp2[CAPACITY_BITS-1:0];

      // Saturating escaped length
      inc = {3'b000, first_of_string} + (has_char ? {1'b0, klen} : 4'd0)
          + {3'b000, end_of_string};
      len_base = first_of_string ? '0 : len_ff;
      len_sum  = {1'b0, len_base} + (LENGTH_BITS + 1)'(inc);
      len_in   = len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];

      // Plan of slots to emit
      plan.mask = '0;
      plan.mask[SLOT_OPEN] = open_emit;
      for (int j = 0; j < CHAR_SLOTS; j++) begin
         plan.mask[int'(SLOT_CHAR) + j] = (3'(j) < n_char);
      end
      plan.mask[SLOT_CLOSE]  = fit_close;
      plan.mask[SLOT_STATUS] = end_of_string;
      plan.char_byte = char_byte;
      plan.kind      = kind;
      plan.overflow  = ovf_in;
      plan_length    = len_in;
   end

   // String state, advanced once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (accept) begin
         wp_ff  <= wp_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

[rtl/json_string_escaper.sv]
// JSON string escaper top level: CSR, plan register, result sequencing and output register.
// Each request is taken into a plan register and its results leave one per cycle through the output
// register while the result channel does not stall; a request with one result (a plain byte, or
// nothing) passes at one per cycle, and a request with more results holds the request channel until
// its last result moves out; it has up to 9, for an opening quote, a \u00XX escape, a closing quote and the status.
// The result register is the only thing between the plan and the result channel, so a
// new request is taken in the cycle the plan's last result moves into it.
module json_string_escaper
   import jse_pkg::*;
#(
   parameter int LENGTH_BITS   = LENGTH_BITS_DEFAULT,
   parameter int CAPACITY_BITS = CAPACITY_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_char_byte,
   input  logic                     req_has_char,
   input  logic                     req_first_of_string,
   input  logic                     req_end_of_string,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_last_result,
   output logic                     rsp_overflow,
   output logic [LENGTH_BITS-1:0]   rsp_needed_length,
   // CSR port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam logic [CAPACITY_BITS-1:0] CAP_RESET =
      (CAPACITY_BITS >= 16) ? CAPACITY_BITS'(CAPACITY_RESET) : '1;

   logic [CAPACITY_BITS-1:0] cap_ff;
   logic                     cap_sel;

   plan_type               new_plan;
   logic [LENGTH_BITS-1:0] new_length;
   logic                   accept;

   logic [NUM_SLOTS-1:0]   mask_ff, mask_in, low, rest;
   logic [7:0]             char_ff;
   kind_type               kind_ff;
   logic                   ovf_ff;
   logic [LENGTH_BITS-1:0] len_ff;

   logic [SLOT_BITS-1:0]   slot;
   logic                   have_slot, out_load;

   logic                   rsp_valid_ff;
   logic [7:0]             byte_ff, byte_in;
   logic                   bval_ff, bval_in;
   logic                   last_ff, last_in;
   logic                   rovf_ff, rovf_in;
   logic [LENGTH_BITS-1:0] rlen_ff, rlen_in;

   // CSR: one register, capacity
   assign cap_sel    = (csr_paddr[2] == CSR_IDX_CAPACITY);
   assign csr_pready = 1'b1;
   assign csr_prdata = cap_sel ? CSR_DATA_BITS'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && cap_sel) begin
         cap_ff <= csr_pwdata[CAPACITY_BITS-1:0];
      end
   end

   // Budget and plan for the incoming request
   jse_budget #(
      .LENGTH_BITS   (LENGTH_BITS),
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_budget (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .char_byte       (req_char_byte),
      .has_char        (req_has_char),
      .first_of_string (req_first_of_string),
      .end_of_string   (req_end_of_string),
      .capacity        (cap_ff),
      .plan            (new_plan),
      .plan_length     (new_length)
   );

   // Pick the earliest pending slot
   always_comb begin
      low       = mask_ff & (~mask_ff + NUM_SLOTS'(1));
      have_slot = |mask_ff;
      slot      = SLOT_OPEN;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            slot = SLOT_BITS'(i);
         end
      end
   end

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign rest      = out_load ? (mask_ff & ~low) : mask_ff;
   assign req_stall = (rest != '0);
   assign accept    = req_valid && !req_stall;
   assign mask_in   = accept ? new_plan.mask : rest;

   // Result byte for the selected slot
   always_comb begin
      byte_in = 8'h00;
      bval_in = 1'b1;
      last_in = 1'b0;
      rovf_in = 1'b0;
      rlen_in = '0;
      case (slot) inside
         SLOT_OPEN, SLOT_CLOSE:    byte_in = CH_QUOTE;
         SLOT_CHAR:                byte_in = (kind_ff == KIND_PLAIN) ? char_ff : CH_BSLASH;
         SLOT_ESC:                 byte_in = (kind_ff == KIND_SHORT) ? short_escape(char_ff)
                                                                     : CH_U;
         SLOT_PAD_HI, SLOT_PAD_LO: byte_in = CH_ZERO;
         SLOT_HEX_HI:              byte_in = hex_digit(char_ff[7:4]);
         SLOT_HEX_LO:              byte_in = hex_digit(char_ff[3:0]);
         SLOT_STATUS: begin
            bval_in = 1'b0;
            last_in = 1'b1;
            rovf_in = ovf_ff;
            rlen_in = len_ff;
         end
         default:                  byte_in = 8'h00;
      endcase
   end

   // Plan register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= new_plan.char_byte;
         kind_ff <= new_plan.kind;
         ovf_ff  <= new_plan.overflow;
         len_ff  <= new_length;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= have_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && have_slot) begin
         byte_ff <= byte_in;
         bval_ff <= bval_in;
         last_ff <= last_in;
         rovf_ff <= rovf_in;
         rlen_ff <= rlen_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_byte_valid    = bval_ff;
   assign rsp_last_result   = last_ff;
   assign rsp_overflow      = rovf_ff;
   assign rsp_needed_length = rlen_ff;

endmodule

[rtl/jse_checker.sv]
// Port-level checks for the JSON string escaper, bound to the top level.
`include "assert_macros.svh"

module jse_checker
   import jse_pkg::*;
#(
   parameter int LENGTH_BITS   = LENGTH_BITS_DEFAULT,
   parameter int CAPACITY_BITS = CAPACITY_BITS_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [7:0]               rsp_out_byte,
   input logic                     rsp_byte_valid,
   input logic                     rsp_last_result,
   input logic                     rsp_overflow,
   input logic [LENGTH_BITS-1:0]   rsp_needed_length,
   input logic                     csr_pready
);

   // Data bytes carry no status
   `JSE_ASSERT_NOW(a_data_clean, clock, reset, rsp_valid && rsp_byte_valid, !rsp_overflow && !rsp_last_result && rsp_needed_length == '0, "data byte carries status fields")

   // Status always counts at least the closing quote
   `JSE_ASSERT_NOW(a_status_len, clock, reset, rsp_valid && !rsp_byte_valid, rsp_last_result && rsp_needed_length != '0, "status result with zero length")

   // A stalled result holds
   `JSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_needed_length), "stalled result changed")

   // CSR port never inserts wait states
   `JSE_ASSERT_NOW(a_pready, clock, reset, 1'b1, csr_pready, "pready dropped")

endmodule

bind json_string_escaper jse_checker #(
   .LENGTH_BITS   (LENGTH_BITS),
   .CAPACITY_BITS (CAPACITY_BITS)
) u_jse_checker (.*);

[verif/json_string_escaper_test.sv]
// Self-checking testbench for the JSON string escaper: directed cases and randomized strings against a predictor.
module json_string_escaper_test;
   import jse_pkg::*;

   localparam int LEN_W        = LENGTH_BITS_DEFAULT;
   localparam int CAP_W        = CAPACITY_BITS_DEFAULT;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 280;
   localparam logic [CSR_ADDR_BITS-1:0] CAPACITY_ADDR = CSR_ADDR_BITS'(4 * CSR_IDX_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   // One item on the result channel
   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      logic             last_result;
      logic             overflow;
      logic [LEN_W-1:0] needed_length;
   } esc_result_type;

   // Predicts the escaped output of each request and checks the results in order
   class escape_scoreboard;
      logic [CAP_W-1:0] capacity;
      logic [CAP_W-1:0] write_pos;
      logic [LEN_W-1:0] length_sum;
      bit               misfit;
      esc_result_type   pending_output[$];
      int               mismatches;
      int               requests;
      int               results;
      int               overflowed_strings;

      function new();
         capacity           = CAP_W'(CAPACITY_RESET);
         write_pos          = '0;
         length_sum         = '0;
         misfit             = 1'b0;
         mismatches         = 0;
         requests           = 0;
         results            = 0;
         overflowed_strings = 0;
      endfunction

      task report(string what);
         mismatches++;
         // keep the log bounded when the block is badly broken
         if (mismatches <= 50) $display("MISMATCH at %0t: %s", $time, what);
      endtask

      // saturating length count
      function void grow(int k);
         int s;
         s = int'(length_sum) + k;
         if (s > int'(LEN_MAX)) length_sum = LEN_MAX;
         else length_sum = s[LEN_W-1:0];
      endfunction

      // the last buffer slot is kept for the terminator
      function void place(logic [7:0] b);
         esc_result_type r;
         if (int'(write_pos) + 1 < int'(capacity)) begin
            r.out_byte      = b;
            r.byte_valid    = 1'b1;
            r.last_result   = 1'b0;
            r.overflow      = 1'b0;
            r.needed_length = '0;
            pending_output.push_back(r);
         end
         write_pos = write_pos + 1'b1;
      endfunction

      // a sequence is written only when all of it fits; the first misfit sticks
      function bit room(int k);
         if (misfit) return 1'b0;
         if (int'(write_pos) + k > int'(capacity)) begin
            misfit = 1'b1;
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function logic [7:0] hex_char(logic [3:0] n);
         if (n < 4'd10) return CH_ZERO + 8'(n);
         return "A" + 8'(n - 4'd10);
      endfunction

      function void escape_request(logic [7:0] c, bit has, bit first, bit last);
         logic [7:0]     letter;
         kind_type       kind;
         int             k;
         esc_result_type st;
         requests++;
         if (first) begin
            write_pos  = '0;
            length_sum = '0;
            misfit     = 1'b0;
            grow(1);
            place(CH_QUOTE);
         end
         if (has) begin
            case (c)
               8'h08:     letter = "b";
               8'h09:     letter = "t";
               8'h0A:     letter = "n";
               8'h0C:     letter = "f";
               8'h0D:     letter = "r";
               CH_QUOTE:  letter = CH_QUOTE;
               CH_BSLASH: letter = CH_BSLASH;
               default:   letter = 8'h00;
            endcase
            if (letter != 8'h00) kind = KIND_SHORT;
            else if (c >= CH_SPACE && c <= CH_TILDE) kind = KIND_PLAIN;
            else kind = KIND_UNICODE;
            k = (kind == KIND_PLAIN) ? 1 : (kind == KIND_SHORT) ? 2 : 6;
            grow(k);
            if (room(k)) begin
               case (kind)
                  KIND_PLAIN: place(c);
                  KIND_SHORT: begin
                     place(CH_BSLASH);
                     place(letter);
                  end
                  default: begin
                     place(CH_BSLASH);
                     place(CH_U);
                     place(CH_ZERO);
                     place(CH_ZERO);
                     place(hex_char(c[7:4]));
                     place(hex_char(c[3:0]));
                  end
               endcase
            end
         end
         if (last) begin
            grow(1);
            // closing quote needs a terminator slot behind it
            if (room(2)) place(CH_QUOTE);
            st.out_byte      = 8'h00;
            st.byte_valid    = 1'b0;
            st.last_result   = 1'b1;
            st.overflow      = misfit;
            st.needed_length = length_sum;
            pending_output.push_back(st);
            if (misfit) overflowed_strings++;
         end
      endfunction

      task check_result(esc_result_type got);
         esc_result_type want;
         results++;
         if (pending_output.size() == 0) begin
            report($sformatf("unexpected result byte=%h bv=%b last=%b ovf=%b len=%0d",
               got.out_byte, got.byte_valid, got.last_result, got.overflow,
               got.needed_length));
            return;
         end
         want = pending_output.pop_front();
         if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
         if (got.byte_valid !== want.byte_valid)
            report($sformatf("byte_valid %b, expected %b", got.byte_valid, want.byte_valid));
         if (got.last_result !== want.last_result)
            report($sformatf("last_result %b, expected %b", got.last_result,
               want.last_result));
         if (got.overflow !== want.overflow)
            report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
         if (got.needed_length !== want.needed_length)
            report($sformatf("needed_length %0d, expected %0d", got.needed_length,
               want.needed_length));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_char_byte = 8'h00;
   logic                     req_has_char = 1'b0;
   logic                     req_first_of_string = 1'b0;
   logic                     req_end_of_string = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [7:0]               rsp_out_byte;
   logic                     rsp_byte_valid;
   logic                     rsp_last_result;
   logic                     rsp_overflow;
   logic [LEN_W-1:0]         rsp_needed_length;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   escape_scoreboard board;
   bit gaps_on = 1'b1;
   bit stall_on = 1'b1;
   int stall_left = 0;
   int config_writes = 0;

   json_string_escaper u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_byte       (req_char_byte),
      .req_has_char        (req_has_char),
      .req_first_of_string (req_first_of_string),
      .req_end_of_string   (req_end_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_last_result     (rsp_last_result),
      .rsp_overflow        (rsp_overflow),
      .rsp_needed_length   (rsp_needed_length),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short idle runs, now and then a long one
   function int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function logic [CAP_W-1:0] next_capacity();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return CAP_W'(1);
         1:       return CAP_W'(2);
         2:       return CAP_W'(CAPACITY_RESET);
         3, 4, 5: return CAP_W'($urandom_range(3, 24));
         6, 7:    return CAP_W'($urandom_range(25, 200));
         8:       return CAP_W'(CAPACITY_RESET - 1);
         default: return CAP_W'($urandom_range(1, 65535));
      endcase
   endfunction

   // raw bytes biased toward the escape classes
   function logic [7:0] next_char();
      logic [7:0] shorts [7];
      shorts = '{8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, CH_QUOTE, CH_BSLASH};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 8'($urandom_range(32, 126));
         5, 6:          return shorts[$urandom_range(0, 6)];
         7:             return 8'($urandom_range(0, 31));
         8:             return 8'($urandom_range(127, 255));
         default:       return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // result channel back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= stall_on && ($urandom_range(0, 2) == 0);
         stall_left <= idle_length();
      end
   end

   // result monitor
   always @(posedge clock) begin
      esc_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.out_byte      = rsp_out_byte;
         got.byte_valid    = rsp_byte_valid;
         got.last_result   = rsp_last_result;
         got.overflow      = rsp_overflow;
         got.needed_length = rsp_needed_length;
         board.check_result(got);
      end
   end

   // drive one request, hold it until taken, then maybe idle
   task push_request(logic [7:0] c, bit has, bit first, bit last);
      int gap;
      req_valid           <= 1'b1;
      req_char_byte       <= c;
      req_has_char        <= has;
      req_first_of_string <= first;
      req_end_of_string   <= last;
      do @(posedge clock); while (req_stall);
      board.escape_request(c, has, first, last);
      gap = gaps_on ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off requests until every expected result is out, plus pipeline slack
   task drain_results();
      req_valid <= 1'b0;
      while (board.pending_output.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_capacity(logic [CAP_W-1:0] value);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.capacity = value;
      config_writes++;
   endtask

   // one string of len requests, most of them carrying a byte; it may continue an open one or be left open
   task send_string(int len, bit continued, bit leave_open);
      int  n;
      bit  has;
      for (int i = 0; i < ((len > 0) ? len : 1); i++) begin
         n   = (len > 0) ? len : 1;
         has = (len > 0) && ($urandom_range(0, 15) != 0);
         push_request(next_char(), has, (i == 0) && !continued,
            (i == n - 1) && !leave_open);
      end
   endtask

   initial begin
      logic [7:0] sweep [13];
      int  phase_end;
      int  len;
      int  target;
      bit  open;
      bit  leave_open;
      board = new();
      sweep = '{8'hFF, CH_SPACE, CH_TILDE, 8'h7F, 8'h1F, 8'h08, 8'h09, 8'h0A, 8'h0B,
                8'h0C, 8'h0D, CH_QUOTE, CH_BSLASH};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no start mark right after reset, then a close on its own
      push_request("A", 1'b1, 1'b0, 1'b0);
      push_request(8'h00, 1'b0, 1'b0, 1'b1);
      // empty string, then NUL and a sweep of every byte class
      push_request(8'h00, 1'b0, 1'b1, 1'b1);
      push_request(8'h00, 1'b1, 1'b1, 1'b0);
      foreach (sweep[i]) push_request(sweep[i], 1'b1, 1'b0, i == 12);
      // continue after a close without a start mark; whole string in one request
      push_request("x", 1'b1, 1'b0, 1'b1);
      push_request("q", 1'b1, 1'b1, 1'b1);
      // tiny budgets, zero included
      write_capacity(CAP_W'(1));
      push_request("a", 1'b1, 1'b1, 1'b1);
      write_capacity(CAP_W'(0));
      push_request("a", 1'b1, 1'b1, 1'b1);
      write_capacity(CAP_W'(4));
      push_request(8'h01, 1'b1, 1'b1, 1'b0);
      push_request("a", 1'b1, 1'b0, 1'b0);
      push_request(8'h00, 1'b0, 1'b0, 1'b1);
      write_capacity(CAP_W'(3));
      push_request("a", 1'b1, 1'b1, 1'b1);
      // budget shrinks below the write position in the middle of a string
      write_capacity(CAP_W'(CAPACITY_RESET));
      push_request("a", 1'b1, 1'b1, 1'b0);
      push_request("b", 1'b1, 1'b0, 1'b0);
      write_capacity(CAP_W'(2));
      push_request("c", 1'b1, 1'b0, 1'b1);

      // random phases, each under its own budget and idling mix
      target = board.requests + RANDOM_ITEMS;
      open   = 1'b0;
      while (board.requests < target) begin
         write_capacity(next_capacity());
         gaps_on   = ($urandom_range(0, 3) != 0);
         stall_on  = ($urandom_range(0, 3) != 0);
         phase_end = board.requests + $urandom_range(20, 50);
         while (board.requests < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: any combination of marks
               push_request(next_char(), $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(0, 1));
            end else begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70)
                                                 : $urandom_range(0, 12);
               leave_open = (board.requests + len >= phase_end) &&
                            ($urandom_range(0, 2) == 0);
               send_string(len, open, leave_open);
               open = leave_open;
            end
         end
      end
      if (open) push_request(8'h00, 1'b0, 1'b0, 1'b1);
      write_capacity(CAP_W'(CAPACITY_RESET));
      gaps_on = 1'b0;
      push_request("z", 1'b1, 1'b1, 1'b1);
      drain_results();

      $display("Sent %0d requests, checked %0d results over %0d capacity settings,",
         board.requests, board.results, config_writes);
      $display("%0d strings ended in overflow, %0d mismatches.",
         board.overflowed_strings, board.mismatches);
      if (board.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/jse_pkg.sv
rtl/jse_budget.sv
rtl/json_string_escaper.sv
rtl/jse_checker.sv
verif/json_string_escaper_test.sv
